// ----- design/arbt_pkg.sv -----
// ----------------------------------------------------------------------------
// arbt_pkg
// Shared widths, codes and item types of the anti-rollback trusted clock.
// ----------------------------------------------------------------------------
`default_nettype none

package arbt_pkg;

  localparam int TIME_BITS = 48;
  localparam int SW        = TIME_BITS + 2;
  localparam int MS_BITS   = 20;
  localparam int SEC_BITS  = 10;
  localparam int IDX_BITS  = 3;

  localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;
  localparam logic [SEC_BITS-1:0]  MAX_SECS  = SEC_BITS'(15 * 60);
  localparam logic [MS_BITS-1:0]   MS_PER_S  = MS_BITS'(1000);

  localparam logic [1:0] OP_RESTORE = 2'd0;
  localparam logic [1:0] OP_OBSERVE = 2'd1;
  localparam logic [1:0] OP_SAMPLE  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_ROLLBACK = 3'd2;
  localparam logic [2:0] ST_BOUNDS   = 3'd3;
  localparam logic [2:0] ST_NO_TIME  = 3'd4;

  localparam logic [IDX_BITS-1:0] REG_TOLERANCE  = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_SKEW       = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_PAIR_VALID = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_SAVED_SIGN = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_SAVED_WALL = 3'd4;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic signed [SW-1:0] stime_t;

  typedef struct packed {
    logic [MS_BITS-1:0] tol_ms;
    logic [MS_BITS-1:0] skew_ms;
    logic               pair_valid;
    time_t              saved_signed_ms;
    time_t              saved_wall_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             wall_valid;
    time_t            wall_ms;
    logic             mono_valid;
    time_t            mono_ms;
    logic             issued_valid;
    time_t            issued_ms;
    logic [TIME_BITS:0] wall_tol;
    stime_t           isk;
    stime_t           isk_m;
    stime_t           issued_off;
    time_t            anc_init;
    stime_t           anc_init_off;
    logic             restore_rb;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       now_valid;
    time_t      now_ms;
    logic       keep_valid;
    time_t      keep_signed_ms;
    time_t      keep_wall_ms;
  } res_t;

endpackage

`default_nettype wire

// ----- design/arbt_cfg.sv -----
// ----------------------------------------------------------------------------
// arbt_cfg
// Configuration registers; tolerance and skew held in milliseconds.
// ----------------------------------------------------------------------------
`default_nettype none

module arbt_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [arbt_pkg::IDX_BITS-1:0] cfg_index,
  input  wire logic [arbt_pkg::TIME_BITS-1:0] cfg_data,
  output arbt_pkg::cfg_t                    cfg
);
  import arbt_pkg::*;

  logic [SEC_BITS-1:0] secs;
  logic [SEC_BITS-1:0] secs_clamped;
  logic [MS_BITS-1:0]  secs_as_ms;

  assign secs         = cfg_data[SEC_BITS-1:0];
  assign secs_clamped = (secs > MAX_SECS) ? MAX_SECS : secs;
  assign secs_as_ms   = MS_BITS'(secs_clamped) * MS_PER_S;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOLERANCE:  cfg.tol_ms <= secs_as_ms;
        REG_SKEW:       cfg.skew_ms <= secs_as_ms;
        REG_PAIR_VALID: cfg.pair_valid <= cfg_data[0];
        REG_SAVED_SIGN: cfg.saved_signed_ms <= cfg_data;
        REG_SAVED_WALL: cfg.saved_wall_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/arbt_prep.sv -----
// ----------------------------------------------------------------------------
// arbt_prep
// Input register; sums that depend only on the item and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module arbt_prep (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire arbt_pkg::cfg_t        cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            op,
  input  wire logic                  wall_valid,
  input  wire logic [arbt_pkg::TIME_BITS-1:0] wall_ms,
  input  wire logic                  mono_valid,
  input  wire logic [arbt_pkg::TIME_BITS-1:0] mono_ms,
  input  wire logic                  issued_valid,
  input  wire logic [arbt_pkg::TIME_BITS-1:0] issued_ms,
  output logic                       s1_valid,
  input  wire logic                  s1_ready,
  output arbt_pkg::item_t            item
);
  import arbt_pkg::*;

  item_t  item_next;
  stime_t mono_s;
  stime_t issued_s;
  logic [TIME_BITS:0] saved_wall_x;

  assign mono_s       = $signed({2'b00, mono_ms});
  assign issued_s     = $signed({2'b00, issued_ms});
  assign saved_wall_x = {1'b0, cfg.saved_wall_ms};

  always_comb begin
    item_next              = '0;
    item_next.op           = op;
    item_next.wall_valid   = wall_valid;
    item_next.wall_ms      = wall_ms;
    item_next.mono_valid   = mono_valid;
    item_next.mono_ms      = mono_ms;
    item_next.issued_valid = issued_valid;
    item_next.issued_ms    = issued_ms;
    item_next.wall_tol     = {1'b0, wall_ms} + (TIME_BITS + 1)'(cfg.tol_ms);
    item_next.isk          = issued_s - $signed(SW'(cfg.skew_ms));
    item_next.isk_m        = issued_s - $signed(SW'(cfg.skew_ms)) - mono_s;
    item_next.issued_off   = issued_s - mono_s;
    item_next.anc_init     = (cfg.pair_valid && cfg.saved_signed_ms > wall_ms) ?
                             cfg.saved_signed_ms : wall_ms;
    item_next.anc_init_off = $signed({2'b00, item_next.anc_init}) - mono_s;
    item_next.restore_rb   = cfg.pair_valid && (item_next.wall_tol < saved_wall_x);
  end

  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/arbt_core.sv -----
// ----------------------------------------------------------------------------
// arbt_core
// High-water and anchor state; trusted now and the result of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module arbt_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire arbt_pkg::cfg_t  cfg,
  input  wire logic            advance,
  input  wire arbt_pkg::item_t item,
  output arbt_pkg::res_t       res
);
  import arbt_pkg::*;

  logic   high_water_valid, high_water_valid_next;
  time_t  signed_high_ms, signed_high_ms_next;
  time_t  wall_high_ms, wall_high_ms_next;
  logic   anchor_valid, anchor_valid_next;
  time_t  anchor_ms, anchor_ms_next;
  time_t  anchor_mono_ms, anchor_mono_ms_next;
  stime_t anchor_off, anchor_off_next;
  logic   rollback_seen, rollback_seen_next;

  logic   tn_pre, rb_hit, nv, sat, skew_ok;
  stime_t sum;
  time_t  derived, now_raw, now;

  always_comb begin
    tn_pre  = anchor_valid && !rollback_seen && item.wall_valid && item.mono_valid &&
              (item.mono_ms >= anchor_mono_ms);
    rb_hit  = tn_pre && high_water_valid && (item.wall_tol < {1'b0, wall_high_ms});
    nv      = tn_pre && !rb_hit;
    sum     = $signed({2'b00, item.mono_ms}) + anchor_off;
    sat     = sum > $signed({2'b00, TIME_MAX});
    derived = sat ? TIME_MAX : sum[TIME_BITS-1:0];
    now_raw = (item.wall_ms > derived) ? item.wall_ms : derived;
    if (high_water_valid && signed_high_ms > now_raw) begin
      now_raw = signed_high_ms;
    end
    now     = nv ? now_raw : '0;
    skew_ok = (item.isk <= $signed({2'b00, item.wall_ms})) || sat ||
              (item.isk_m <= anchor_off) ||
              (high_water_valid && item.isk <= $signed({2'b00, signed_high_ms}));
  end

  always_comb begin
    high_water_valid_next = high_water_valid;
    signed_high_ms_next   = signed_high_ms;
    wall_high_ms_next     = wall_high_ms;
    anchor_valid_next     = anchor_valid;
    anchor_ms_next        = anchor_ms;
    anchor_mono_ms_next   = anchor_mono_ms;
    anchor_off_next       = anchor_off;
    rollback_seen_next    = rollback_seen || rb_hit;
    res                   = '0;
    case (item.op)
      OP_RESTORE: begin
        rollback_seen_next = 1'b0;
        if (!item.wall_valid || !item.mono_valid) begin
          res.status = ST_INVALID;
        end else if (item.restore_rb) begin
          rollback_seen_next = 1'b1;
          res.status         = ST_ROLLBACK;
        end else begin
          high_water_valid_next = cfg.pair_valid;
          signed_high_ms_next   = cfg.saved_signed_ms;
          wall_high_ms_next     = cfg.saved_wall_ms;
          anchor_ms_next        = item.anc_init;
          anchor_mono_ms_next   = item.mono_ms;
          anchor_off_next       = item.anc_init_off;
          anchor_valid_next     = 1'b1;
        end
      end
      OP_OBSERVE: begin
        if (!nv) begin
          res.status = rollback_seen_next ? ST_ROLLBACK : ST_NO_TIME;
        end else if (!item.issued_valid || !skew_ok) begin
          res.status = ST_BOUNDS;
        end else begin
          if (!high_water_valid || item.issued_ms > signed_high_ms) begin
            signed_high_ms_next = item.issued_ms;
          end
          if (!high_water_valid || item.wall_ms > wall_high_ms) begin
            wall_high_ms_next = item.wall_ms;
          end
          high_water_valid_next = 1'b1;
          if (item.issued_ms > anchor_ms) begin
            anchor_ms_next      = item.issued_ms;
            anchor_mono_ms_next = item.mono_ms;
            anchor_off_next     = item.issued_off;
          end
        end
      end
      OP_SAMPLE: begin
        res.status    = nv ? ST_OK : (rollback_seen_next ? ST_ROLLBACK : ST_NO_TIME);
        res.now_valid = nv;
        res.now_ms    = now;
        if (high_water_valid) begin
          res.keep_valid     = 1'b1;
          res.keep_signed_ms = signed_high_ms;
          res.keep_wall_ms   = (nv && now > wall_high_ms) ? now : wall_high_ms;
        end
      end
      default: begin
        rollback_seen_next = rollback_seen;
        res.status         = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_water_valid <= 1'b0;
      signed_high_ms   <= '0;
      wall_high_ms     <= '0;
      anchor_valid     <= 1'b0;
      anchor_ms        <= '0;
      anchor_mono_ms   <= '0;
      anchor_off       <= '0;
      rollback_seen    <= 1'b0;
    end else if (advance) begin
      high_water_valid <= high_water_valid_next;
      signed_high_ms   <= signed_high_ms_next;
      wall_high_ms     <= wall_high_ms_next;
      anchor_valid     <= anchor_valid_next;
      anchor_ms        <= anchor_ms_next;
      anchor_mono_ms   <= anchor_mono_ms_next;
      anchor_off       <= anchor_off_next;
      rollback_seen    <= rollback_seen_next;
    end
  end

  a_off_consistent: assert property (@(posedge clk) disable iff (rst)
    anchor_off == $signed({2'b00, anchor_ms}) - $signed({2'b00, anchor_mono_ms}))
    else $error("anchor offset out of step with anchor");

  a_hw_needs_anchor: assert property (@(posedge clk) disable iff (rst)
    high_water_valid |-> anchor_valid)
    else $error("high-water valid without anchor");

  a_restore_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item.op == OP_RESTORE && !item.restore_rb |=> !rollback_seen)
    else $error("restore left rollback latched");

  a_now_floor: assert property (@(posedge clk) disable iff (rst)
    advance && res.now_valid |-> res.now_ms >= item.wall_ms && res.status == ST_OK)
    else $error("trusted now below wall sample");

endmodule

`default_nettype wire

// ----- design/arbt_out.sv -----
// ----------------------------------------------------------------------------
// arbt_out
// Result register towards the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module arbt_out (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s1_valid,
  output logic                s1_ready,
  input  wire arbt_pkg::res_t res_next,
  output logic                out_valid,
  input  wire logic           out_ready,
  output arbt_pkg::res_t      res
);
  import arbt_pkg::*;

  assign s1_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/anti_rollback_trusted_clock_core.sv -----
// ----------------------------------------------------------------------------
// anti_rollback_trusted_clock_core
// Trusted wall time with rollback detection and signed-time high-water marks.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    op, wall, mono, issued samples
//   out      source     out_valid / out_ready  status, now, keep pair
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while out_ready stays high; an accepted item
// passes through the input register, then the result register, before
// out_valid rises; state updates as an item leaves the input register, so
// consecutive items see each other's effects
// synchronous reset clears state and configuration; no clearing pass
// a stalled output holds its result while one more item waits in the input
// register; cfg_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module anti_rollback_trusted_clock_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [arbt_pkg::IDX_BITS-1:0]  cfg_index,
  input  wire logic [arbt_pkg::TIME_BITS-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     op,
  input  wire logic                           wall_valid,
  input  wire logic [arbt_pkg::TIME_BITS-1:0] wall_ms,
  input  wire logic                           mono_valid,
  input  wire logic [arbt_pkg::TIME_BITS-1:0] mono_ms,
  input  wire logic                           issued_valid,
  input  wire logic [arbt_pkg::TIME_BITS-1:0] issued_ms,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [2:0]                          status,
  output logic                                now_valid,
  output logic [arbt_pkg::TIME_BITS-1:0]      now_ms,
  output logic                                keep_valid,
  output logic [arbt_pkg::TIME_BITS-1:0]      keep_signed_ms,
  output logic [arbt_pkg::TIME_BITS-1:0]      keep_wall_ms
);
  import arbt_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res_next;
  res_t  res;
  logic  s1_valid;
  logic  s1_ready;

  assign cfg_ready = 1'b1;

  arbt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  arbt_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .wall_valid   (wall_valid),
    .wall_ms      (wall_ms),
    .mono_valid   (mono_valid),
    .mono_ms      (mono_ms),
    .issued_valid (issued_valid),
    .issued_ms    (issued_ms),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .item         (item)
  );

  arbt_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (s1_valid && s1_ready),
    .item    (item),
    .res     (res_next)
  );

  arbt_out u_out (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .res_next  (res_next),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign status         = res.status;
  assign now_valid      = res.now_valid;
  assign now_ms         = res.now_ms;
  assign keep_valid     = res.keep_valid;
  assign keep_signed_ms = res.keep_signed_ms;
  assign keep_wall_ms   = res.keep_wall_ms;

endmodule

`default_nettype wire
